FILE: rtl/cwfc_pkg.sv
// Shared types and constants for the credit window flow control block.
package cwfc_pkg;

  // Request codes
  localparam logic [2:0] REQ_GRANT   = 3'd0;
  localparam logic [2:0] REQ_CONSUME = 3'd1;
  localparam logic [2:0] REQ_TAKEALL = 3'd2;
  localparam logic [2:0] REQ_POST    = 3'd3;
  localparam logic [2:0] REQ_SEND    = 3'd4;
  localparam logic [2:0] REQ_ADV     = 3'd5;
  localparam logic [2:0] REQ_STAT    = 3'd6;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FLOW_EN   = 2'd0;
  localparam logic [1:0] REG_PEER_DEP  = 2'd1;
  localparam logic [1:0] REG_OWN_DEP   = 2'd2;
  localparam logic [1:0] REG_NOTIFY_IV = 2'd3;

  // Running total slots
  localparam int NUM_TOTALS = 7;
  localparam logic [2:0] T_POSTED    = 3'd0;
  localparam logic [2:0] T_NOTIFIED  = 3'd1;
  localparam logic [2:0] T_POST_ERR  = 3'd2;
  localparam logic [2:0] T_RECEIVED  = 3'd3;
  localparam logic [2:0] T_CONSUMED  = 3'd4;
  localparam logic [2:0] T_RECV_ERR  = 3'd5;
  localparam logic [2:0] T_SHORTFALL = 3'd6;

  // Reset values of the registers
  localparam logic [15:0] PEER_DEP_RST  = 16'd1024;
  localparam logic [15:0] OWN_DEP_RST   = 16'd1024;
  localparam logic [15:0] NOTIFY_IV_RST = 16'd64;

  typedef logic [15:0] cnt_t;
  typedef logic [63:0] total_t;

endpackage

FILE: rtl/credit_window_flow_control.sv
// Each event is registered in the input stage, and its result in the result stage.
// One event per cycle unless out_ready stalls the result stage; the credit and total
// update is one pass of add/compare logic between the input and result registers.
// One extra event is taken into the input stage while a result waits on out_ready.
// Reset (rst_n low, synchronous): counters and all seven totals clear to zero, registers
// return to flow on, depths 1024, notify interval 64; both stages empty.
module credit_window_flow_control
  import cwfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_amount,
  input  logic [2:0]  in_stat_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_count,
  output logic [15:0] out_credit_now,
  output logic [15:0] out_posted_now,
  output logic        out_over_depth,
  output logic        out_overflow_rejected,
  output logic        out_notify_sent,
  output logic [63:0] out_stat_value,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic flow_en_r;
  cnt_t peer_dep_r, own_dep_r, notify_iv_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_en_r   <= 1'b1;
      peer_dep_r  <= PEER_DEP_RST;
      own_dep_r   <= OWN_DEP_RST;
      notify_iv_r <= NOTIFY_IV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FLOW_EN:   flow_en_r   <= pwdata[0];
        REG_PEER_DEP:  peer_dep_r  <= pwdata[15:0];
        REG_OWN_DEP:   own_dep_r   <= pwdata[15:0];
        REG_NOTIFY_IV: notify_iv_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_FLOW_EN:   prdata = {31'd0, flow_en_r};
      REG_PEER_DEP:  prdata = {16'd0, peer_dep_r};
      REG_OWN_DEP:   prdata = {16'd0, own_dep_r};
      REG_NOTIFY_IV: prdata = {16'd0, notify_iv_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Input stage
  logic       s1_valid_r;
  logic [2:0] s1_req_r;
  cnt_t       s1_amt_r;
  logic [2:0] s1_sidx_r;
  logic       s1_adv;
  logic       step;
  logic       out_valid_r;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_amt_r  <= in_amount;
      s1_sidx_r <= in_stat_index;
    end
  end

  // Credit state and running totals
  cnt_t   credit_r, posted_r;
  total_t tot_r [NUM_TOTALS];

  cnt_t   credit_nxt, posted_nxt, result_nxt;
  logic   over_nxt, rej_nxt, sent_nxt;
  total_t stat_nxt;
  cnt_t   inc [NUM_TOTALS];
  logic [16:0] grant_sum, post_sum;

  assign grant_sum = {1'b0, credit_r} + {1'b0, s1_amt_r};
  assign post_sum  = {1'b0, posted_r} + {1'b0, s1_amt_r};

  // Event decode: one add/compare/clear per event
  always_comb begin
    credit_nxt = credit_r;
    posted_nxt = posted_r;
    result_nxt = '0;
    over_nxt   = 1'b0;
    rej_nxt    = 1'b0;
    sent_nxt   = 1'b0;
    stat_nxt   = '0;
    for (int i = 0; i < NUM_TOTALS; i++) inc[i] = '0;

    if (s1_req_r == REQ_STAT) begin
      if (s1_sidx_r != 3'(NUM_TOTALS)) stat_nxt = tot_r[s1_sidx_r];
    end else if (flow_en_r) begin
      case (s1_req_r)
        REQ_GRANT: begin
          if (grant_sum[16]) begin
            inc[T_RECV_ERR] = s1_amt_r;
            rej_nxt         = 1'b1;
            result_nxt      = credit_r;
          end else begin
            inc[T_RECEIVED] = s1_amt_r;
            over_nxt        = grant_sum[15:0] > peer_dep_r;
            credit_nxt      = grant_sum[15:0];
            result_nxt      = grant_sum[15:0];
          end
        end
        REQ_CONSUME: begin
          if (credit_r >= s1_amt_r) begin
            credit_nxt      = credit_r - s1_amt_r;
            inc[T_CONSUMED] = s1_amt_r;
            result_nxt      = s1_amt_r;
          end else begin
            inc[T_SHORTFALL] = s1_amt_r - credit_r;
            inc[T_CONSUMED]  = credit_r;
            credit_nxt       = '0;
            result_nxt       = credit_r;
          end
        end
        REQ_TAKEALL: begin
          inc[T_CONSUMED] = credit_r;
          credit_nxt      = '0;
          result_nxt      = credit_r;
        end
        REQ_POST: begin
          if (post_sum[16]) begin
            inc[T_POST_ERR] = s1_amt_r;
            rej_nxt         = 1'b1;
            result_nxt      = posted_r;
          end else begin
            inc[T_POSTED] = s1_amt_r;
            over_nxt      = post_sum[15:0] > own_dep_r;
            posted_nxt    = post_sum[15:0];
            result_nxt    = post_sum[15:0];
          end
        end
        REQ_SEND: begin
          // piggyback advertise once the posted count reaches the interval
          if (posted_r >= notify_iv_r) begin
            inc[T_NOTIFIED] = posted_r;
            posted_nxt      = '0;
            result_nxt      = posted_r;
            sent_nxt        = posted_r != '0;
          end
        end
        REQ_ADV: begin
          inc[T_NOTIFIED] = posted_r;
          posted_nxt      = '0;
          result_nxt      = posted_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      posted_r <= '0;
      for (int i = 0; i < NUM_TOTALS; i++) tot_r[i] <= '0;
    end else if (step) begin
      credit_r <= credit_nxt;
      posted_r <= posted_nxt;
      for (int i = 0; i < NUM_TOTALS; i++) tot_r[i] <= tot_r[i] + {48'd0, inc[i]};
    end
  end

  // Result stage
  cnt_t   res_count_r, res_credit_r, res_posted_r;
  logic   res_over_r, res_rej_r, res_sent_r;
  total_t res_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_count_r  <= result_nxt;
      res_credit_r <= credit_nxt;
      res_posted_r <= posted_nxt;
      res_over_r   <= over_nxt;
      res_rej_r    <= rej_nxt;
      res_sent_r   <= sent_nxt;
      res_stat_r   <= stat_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_count      = res_count_r;
  assign out_credit_now        = res_credit_r;
  assign out_posted_now        = res_posted_r;
  assign out_over_depth        = res_over_r;
  assign out_overflow_rejected = res_rej_r;
  assign out_notify_sent       = res_sent_r;
  assign out_stat_value        = res_stat_r;

  // Checks
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input refused while a stage is free");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("stalled event lost from input stage");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_over_r && res_rej_r))
    else $error("over-depth and overflow flagged together");

  a_sent_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_sent_r) |-> (res_posted_r == '0 && res_count_r != '0))
    else $error("notify sent without clearing a nonzero posted count");

  a_step_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed event produced no result");

endmodule

FILE: bench/credit_window_flow_control_tb.sv
// Testbench for credit_window_flow_control: random and directed events against a local model.
module credit_window_flow_control_tb
  import cwfc_pkg::*;
;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int CLK_HALF = 4;
  localparam int RUN_LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [2:0] op;
    cnt_t       amt;
    logic [2:0] idx;
  } credit_event_t;

  typedef struct packed {
    cnt_t       result_count;
    cnt_t       credit_now;
    cnt_t       posted_now;
    logic       over_depth;
    logic       overflow_rejected;
    logic       notify_sent;
    total_t     stat_value;
  } credit_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [15:0] in_amount;
  logic [2:0]  in_stat_index;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_result_count;
  logic [15:0] out_credit_now;
  logic [15:0] out_posted_now;
  logic        out_over_depth;
  logic        out_overflow_rejected;
  logic        out_notify_sent;
  logic [63:0] out_stat_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  credit_window_flow_control u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_amount             (in_amount),
    .in_stat_index         (in_stat_index),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_count      (out_result_count),
    .out_credit_now        (out_credit_now),
    .out_posted_now        (out_posted_now),
    .out_over_depth        (out_over_depth),
    .out_overflow_rejected (out_overflow_rejected),
    .out_notify_sent       (out_notify_sent),
    .out_stat_value        (out_stat_value),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // Model state and register copies
  cnt_t        credit_win;
  cnt_t        posted_cnt;
  total_t      totals [NUM_TOTALS];
  logic        cfg_flow_en;
  cnt_t        cfg_peer_depth;
  cnt_t        cfg_own_depth;
  cnt_t        cfg_notify_iv;

  credit_event_t  event_q[$];
  credit_result_t expected_q[$];
  int unsigned    events_queued;
  int unsigned    results_seen;
  int unsigned    error_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Checked add into a 16-bit counter; refused amounts go to the error total
  function automatic cnt_t add_credit(inout cnt_t ctr, input cnt_t amt, input cnt_t depth,
                                      input logic [2:0] ok_slot, input logic [2:0] err_slot,
                                      inout logic over, inout logic rej);
    logic [16:0] sum;
    sum = {1'b0, ctr} + {1'b0, amt};
    if (sum > 17'h0FFFF) begin
      totals[err_slot] += total_t'(amt);
      rej = 1'b1;
      return ctr;
    end
    if (sum > {1'b0, depth}) over = 1'b1;
    totals[ok_slot] += total_t'(amt);
    ctr = sum[15:0];
    return ctr;
  endfunction

  // Updates the model for one event and returns the result it should produce
  function automatic credit_result_t predict_credit_event(logic [2:0] op, cnt_t amt,
                                                          logic [2:0] idx);
    credit_result_t r;
    r = '0;
    if (op == REQ_STAT) begin
      if (idx < NUM_TOTALS) r.stat_value = totals[idx];
    end else if (cfg_flow_en) begin
      case (op)
        REQ_GRANT: begin
          r.result_count = add_credit(credit_win, amt, cfg_peer_depth, T_RECEIVED,
                                      T_RECV_ERR, r.over_depth, r.overflow_rejected);
        end
        REQ_CONSUME: begin
          if (credit_win >= amt) begin
            credit_win -= amt;
            totals[T_CONSUMED] += total_t'(amt);
            r.result_count = amt;
          end else begin
            totals[T_SHORTFALL] += total_t'(amt - credit_win);
            totals[T_CONSUMED] += total_t'(credit_win);
            r.result_count = credit_win;
            credit_win = '0;
          end
        end
        REQ_TAKEALL: begin
          totals[T_CONSUMED] += total_t'(credit_win);
          r.result_count = credit_win;
          credit_win = '0;
        end
        REQ_POST: begin
          r.result_count = add_credit(posted_cnt, amt, cfg_own_depth, T_POSTED,
                                      T_POST_ERR, r.over_depth, r.overflow_rejected);
        end
        REQ_SEND: begin
          if (posted_cnt >= cfg_notify_iv) begin
            totals[T_NOTIFIED] += total_t'(posted_cnt);
            r.result_count = posted_cnt;
            r.notify_sent = (posted_cnt != '0);
            posted_cnt = '0;
          end
        end
        REQ_ADV: begin
          totals[T_NOTIFIED] += total_t'(posted_cnt);
          r.result_count = posted_cnt;
          posted_cnt = '0;
        end
        default: begin
        end
      endcase
    end
    r.credit_now = credit_win;
    r.posted_now = posted_cnt;
    return r;
  endfunction

  // Driver: presents queued events, predicts each one on transfer
  always @(posedge clk) begin
    credit_event_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(predict_credit_event(in_req_type, in_amount, in_stat_index));
      if (!in_valid || in_ready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = event_q.pop_front();
          in_valid      <= 1'b1;
          in_req_type   <= nxt.op;
          in_amount     <= nxt.amt;
          in_stat_index <= nxt.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Monitor: random back-pressure, compares each result transfer with the oldest prediction
  always @(posedge clk) begin
    credit_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("result_count", 64'(want.result_count), 64'(out_result_count));
        check_field("credit_now", 64'(want.credit_now), 64'(out_credit_now));
        check_field("posted_now", 64'(want.posted_now), 64'(out_posted_now));
        check_field("over_depth", 64'(want.over_depth), 64'(out_over_depth));
        check_field("overflow_rejected", 64'(want.overflow_rejected),
                    64'(out_overflow_rejected));
        check_field("notify_sent", 64'(want.notify_sent), 64'(out_notify_sent));
        check_field("stat_value", want.stat_value, out_stat_value);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_event(input logic [2:0] op, input cnt_t amt, input logic [2:0] idx);
    credit_event_t e;
    e.op  = op;
    e.amt = amt;
    e.idx = idx;
    event_q.push_back(e);
    events_queued++;
  endtask

  // Wait until every event has come back, then give the pipeline slack before returning
  task automatic drain();
    wait (results_seen >= events_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FLOW_EN:   cfg_flow_en    = val[0];
      REG_PEER_DEP:  cfg_peer_depth = val[15:0];
      REG_OWN_DEP:   cfg_own_depth  = val[15:0];
      REG_NOTIFY_IV: cfg_notify_iv  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic flow, input cnt_t peer, input cnt_t own,
                           input cnt_t iv);
    apb_write(REG_FLOW_EN, {31'd0, flow});
    apb_write(REG_PEER_DEP, {16'd0, peer});
    apb_write(REG_OWN_DEP, {16'd0, own});
    apb_write(REG_NOTIFY_IV, {16'd0, iv});
  endtask

  // Amounts lean small so counters build up, with a share near the 16-bit limit
  function automatic cnt_t pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 16) return 16'hFFFF;
    if (r < 24) return cnt_t'($urandom_range(65535, 65000));
    if (r < 54) return cnt_t'($urandom_range(15, 0));
    if (r < 80) return cnt_t'($urandom_range(255, 0));
    return cnt_t'($urandom_range(65535, 0));
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 24) return REQ_GRANT;
    if (r < 42) return REQ_CONSUME;
    if (r < 47) return REQ_TAKEALL;
    if (r < 68) return REQ_POST;
    if (r < 82) return REQ_SEND;
    if (r < 88) return REQ_ADV;
    if (r < 97) return REQ_STAT;
    return REQ_UNUSED;
  endfunction

  // Random events; the sender holds off mid-block until all results are back
  task automatic run_block(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      push_event(pick_op(), pick_amount(), 3'($urandom_range(7, 0)));
    end
    drain();
  endtask

  // Stimulus
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_GRANT;
    in_amount     = '0;
    in_stat_index = '0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    events_queued = 0;
    results_seen  = 0;
    error_count   = 0;
    credit_win     = '0;
    posted_cnt     = '0;
    cfg_flow_en    = 1'b1;
    cfg_peer_depth = PEER_DEP_RST;
    cfg_own_depth  = OWN_DEP_RST;
    cfg_notify_iv  = NOTIFY_IV_RST;
    for (int i = 0; i < NUM_TOTALS; i++) totals[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, zero amounts, depth and overflow edges, shortfall, notify
    push_event(REQ_GRANT, 16'd0, 3'd0);
    push_event(REQ_GRANT, 16'd1000, 3'd7);
    push_event(REQ_GRANT, 16'd100, 3'd0);
    push_event(REQ_GRANT, 16'hFFFF, 3'd0);
    push_event(REQ_CONSUME, 16'd50, 3'd0);
    push_event(REQ_CONSUME, 16'hFFFF, 3'd0);
    push_event(REQ_TAKEALL, 16'd0, 3'd0);
    push_event(REQ_GRANT, 16'hFFFF, 3'd0);
    push_event(REQ_GRANT, 16'd1, 3'd0);
    push_event(REQ_TAKEALL, 16'd0, 3'd0);
    push_event(REQ_POST, 16'd10, 3'd0);
    push_event(REQ_SEND, 16'd0, 3'd0);
    push_event(REQ_POST, 16'd60, 3'd0);
    push_event(REQ_SEND, 16'd0, 3'd0);
    push_event(REQ_SEND, 16'd0, 3'd0);
    push_event(REQ_POST, 16'hFFFF, 3'd0);
    push_event(REQ_POST, 16'd1, 3'd0);
    push_event(REQ_ADV, 16'd0, 3'd0);
    push_event(REQ_ADV, 16'd0, 3'd0);
    push_event(REQ_UNUSED, 16'hFFFF, 3'd7);
    for (int i = 0; i < 8; i++) push_event(REQ_STAT, 16'd0, 3'(i));
    drain();

    // Sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 81;
    run_block(190);
    write_all(1'b1, 16'd0, 16'd0, 16'd1);
    run_block(190);

    // Roles swapped; includes a stretch with flow disabled
    send_idle_pct = 81;
    recv_idle_pct = 25;
    write_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_block(190);
    apb_write(REG_FLOW_EN, 32'd0);
    run_block(60);

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(1'b1, 16'd300, 16'd200, 16'd0);
    run_block(190);
    write_all(1'b1, cnt_t'($urandom_range(65535, 0)), cnt_t'($urandom_range(65535, 0)),
              cnt_t'($urandom_range(65535, 0)));
    run_block(190);
    write_all(1'b1, PEER_DEP_RST, OWN_DEP_RST, NOTIFY_IV_RST);
    run_block(190);

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * RUN_LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

endmodule
